[src/mexp_pkg.sv]
package mexp_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } t_state;

endpackage

[src/mexp_mulmod.sv]
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_n,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_n;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;
    logic [WIDTH-1:0] n_acc;

    // One multiplier bit per cycle, most significant first: double, then add.
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_n}) ? dbl - {1'b0, r_n} : dbl;
        sum     = dbl_red + {1'b0, r_a};
        sum_red = (sum >= {1'b0, r_n}) ? sum - {1'b0, r_n} : sum;
        n_acc   = r_b[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[src/modular_exponentiation.sv]
// Run time is set by the bit-serial modular multiplier that performs every square and multiply.
// Exponent zero or modulus zero skips the multiplier and goes straight to the result.
// Throughput: one item at a time; the next item is accepted while a result waits at the output.
// Reset (synchronous, active low) sets modulus and exponent to 1 and empties the block.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter  int WIDTH   = 32,
    localparam int TDATA_W = ((WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // message
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // result
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exponent;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_ebits, n_ebits;
    logic [CNT_W-1:0] r_ecnt, n_ecnt;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_data, n_out_data;

    logic             mm_start;
    logic             mm_done;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_result;
    logic             in_xfer;

    mexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_n     (r_modulus),
        .o_done  (mm_done),
        .o_result(mm_result)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WIDTH'(1);
            r_exponent <= WIDTH'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_base      = r_base;
        n_ebits     = r_ebits;
        n_ecnt      = r_ecnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mm_start    = 1'b0;
        mm_a        = r_acc;
        mm_b        = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_ebits = r_exponent;
                    n_ecnt  = CNT_W'(WIDTH);
                    if (r_exponent == '0) begin
                        n_acc   = WIDTH'(1);
                        n_state = ST_DONE;
                    end else if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_acc    = (r_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
                        mm_start = 1'b1;
                        mm_a     = WIDTH'(1);
                        mm_b     = s_axis_tdata[WIDTH-1:0];
                        n_state  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_done) begin
                    n_base   = mm_result;
                    mm_start = 1'b1;
                    n_state  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (mm_done) begin
                    n_acc = mm_result;
                    if (r_ebits[WIDTH-1]) begin
                        mm_start = 1'b1;
                        mm_a     = mm_result;
                        mm_b     = r_base;
                        n_state  = ST_MULT;
                    end else begin
                        n_ebits = {r_ebits[WIDTH-2:0], 1'b0};
                        n_ecnt  = r_ecnt - CNT_W'(1);
                        if (r_ecnt == CNT_W'(1)) begin
                            n_state = ST_DONE;
                        end else begin
                            mm_start = 1'b1;
                            mm_a     = mm_result;
                            mm_b     = mm_result;
                        end
                    end
                end
            end
            ST_MULT: begin
                if (mm_done) begin
                    n_acc   = mm_result;
                    n_ebits = {r_ebits[WIDTH-2:0], 1'b0};
                    n_ecnt  = r_ecnt - CNT_W'(1);
                    if (r_ecnt == CNT_W'(1)) begin
                        n_state = ST_DONE;
                    end else begin
                        mm_start = 1'b1;
                        mm_a     = mm_result;
                        mm_b     = mm_result;
                        n_state  = ST_SQUARE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ecnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ecnt      <= n_ecnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_ebits    <= n_ebits;
        r_out_data <= n_out_data;
    end

`ifndef ASSERT_OFF
    a_done_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == ST_REDUCE || r_state == ST_SQUARE || r_state == ST_MULT))
        else $error("multiplier finished outside an exponentiation");

    a_product_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (mm_result < r_modulus))
        else $error("modular product not below modulus");

    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQUARE || r_state == ST_MULT) |-> (r_ecnt != '0))
        else $error("exponent bit count exhausted during work");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

[test/modular_exponentiation_test.sv]
module modular_exponentiation_test;
    import mexp_pkg::*;

    localparam int WIDTH          = 32;
    localparam int RUN_LIMIT      = 3_000_000;
    localparam int HOLD_CYCLES    = 6000;
    localparam int SETTLE_CYCLES  = 2200;
    localparam int KEY_PHASES     = 12;
    localparam int ITEMS_PER_KEY  = 22;

    typedef struct packed {
        logic             rekey;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] message;
        logic             known;
        logic [WIDTH-1:0] result;
    } t_vector;

    localparam int N_DIRECTED = 23;
    localparam t_vector DIRECTED [N_DIRECTED] = '{
        '{1'b0, 32'd1,          32'd1,          32'd0,          1'b1, 32'd0},
        '{1'b0, 32'd1,          32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
        '{1'b1, 32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
        '{1'b0, 32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
        '{1'b1, 32'd0,          32'd5,          32'd7,          1'b1, 32'd0},
        '{1'b0, 32'd0,          32'd5,          32'd0,          1'b1, 32'd0},
        '{1'b1, 32'd0,          32'd0,          32'd9,          1'b1, 32'd1},
        '{1'b1, 32'd1,          32'd0,          32'd0,          1'b1, 32'd1},
        '{1'b1, 32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
        '{1'b1, 32'hFFFF_FFFB,  32'hFFFF_FFFF,  32'd2,          1'b0, 32'd0},
        '{1'b0, 32'hFFFF_FFFB,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'd0},
        '{1'b0, 32'hFFFF_FFFB,  32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0},
        '{1'b0, 32'hFFFF_FFFB,  32'hFFFF_FFFF,  32'd1,          1'b1, 32'd1},
        '{1'b1, 32'd3233,       32'd17,         32'd65,         1'b1, 32'd2790},
        '{1'b1, 32'd3233,       32'd2753,       32'd2790,       1'b1, 32'd65},
        '{1'b1, 32'hFFFF_FFFF,  32'd2,          32'hFFFF_FFFE,  1'b1, 32'd1},
        '{1'b0, 32'hFFFF_FFFF,  32'd2,          32'h8000_0000,  1'b0, 32'd0},
        '{1'b1, 32'd2,          32'hFFFF_FFFF,  32'd3,          1'b1, 32'd1},
        '{1'b0, 32'd2,          32'hFFFF_FFFF,  32'd4,          1'b1, 32'd0},
        '{1'b1, 32'h8000_0000,  32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'd0},
        '{1'b1, 32'h1234_5679,  32'h8000_0001,  32'hDEAD_BEEF,  1'b0, 32'd0},
        '{1'b1, 32'd65537,      32'd65537,      32'd65536,      1'b1, 32'd65536},
        '{1'b1, 32'h7FFF_FFFF,  32'h5555_5555,  32'h7FFF_FFFF,  1'b1, 32'd0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WIDTH-1:0]     s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WIDTH-1:0]     m_axis_tdata;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_MODULUS;
    logic [WIDTH-1:0]     i_cfg_data    = '0;

    logic [WIDTH-1:0] key_modulus  = 32'd1;
    logic [WIDTH-1:0] key_exponent = 32'd1;
    logic [WIDTH-1:0] pending_results [$];
    logic [WIDTH-1:0] want;
    int               failures    = 0;
    int               cycle_count = 0;
    int               hold_ticket = 0;
    logic             steady_run  = 1'b0;

    modular_exponentiation #(.WIDTH(WIDTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Square-and-multiply with double-width products, so every step is exact.
    function automatic logic [WIDTH-1:0] mod_power(input logic [WIDTH-1:0] base,
                                                   input logic [WIDTH-1:0] power,
                                                   input logic [WIDTH-1:0] modv);
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] reduced;
        if (power == '0) return WIDTH'(1);
        if (modv == '0) return '0;
        reduced = (2*WIDTH)'(base % modv);
        acc = 64'd1 % modv;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            acc = (acc * acc) % modv;
            if (power[i]) acc = (acc * reduced) % modv;
        end
        return acc[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(2, 255);
            4: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'd65537;
            4: return $urandom_range(2, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_message();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return key_modulus - 32'd1;
            4, 5: return (key_modulus != '0) ? $urandom % key_modulus : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // The valid line is left high on return so that back-to-back transfers need no toggle.
    task automatic send_message(input logic [WIDTH-1:0] msg, input logic known,
                                input logic [WIDTH-1:0] typed_result);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= msg;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(known ? typed_result
                                        : mod_power(msg, key_exponent, key_modulus));
    endtask

    task automatic sender_gap();
        if (!steady_run) begin
            if ($urandom_range(99) < 8) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2500)) @(posedge i_clk);
            end else begin
                while ($urandom_range(99) < 31) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [WIDTH-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_MODULUS) key_modulus = value;
        else key_exponent = value;
    endtask

    task automatic load_key(input logic [WIDTH-1:0] modv, input logic [WIDTH-1:0] power);
        drain_results();
        if ($urandom_range(1)) begin
            write_register(CFG_MODULUS, modv);
            write_register(CFG_EXPONENT, power);
        end else begin
            write_register(CFG_EXPONENT, power);
            write_register(CFG_MODULUS, modv);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int seen;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != seen) begin
                seen = hold_ticket;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady_run) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result: expected nothing, got %h", m_axis_tdata);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("result: expected %h, got %h", want, m_axis_tdata);
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].rekey) load_key(DIRECTED[r].modulus, DIRECTED[r].exponent);
            send_message(DIRECTED[r].message, DIRECTED[r].known, DIRECTED[r].result);
            sender_gap();
        end

        for (int phase = 0; phase < KEY_PHASES; phase++) begin
            load_key(pick_modulus(), pick_exponent());
            steady_run <= (phase == 5);
            for (int n = 0; n < ITEMS_PER_KEY; n++) begin
                // The receiver stops for long enough that the block backs up on its input.
                if (phase == 2 && n == 4) hold_ticket <= hold_ticket + 1;
                if (phase == 8 && n == 12) drain_results();
                send_message(pick_message(), 1'b0, '0);
                sender_gap();
            end
        end

        steady_run <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation.sv
test/modular_exponentiation_test.sv
